// ===== sv/srit_pkg.sv =====
// Shared types and constants of the SRTP roll-over index tracker.
package srit_pkg;

	localparam int STREAM_SLOTS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic CMD_CHECK = 1'b0;
	localparam logic CMD_COMMIT = 1'b1;

	localparam logic [7:0] HDR_FIRST_BYTE = 8'h80;
	localparam logic [10:0] MIN_LENGTH = 11'd28;
	localparam logic [10:0] TAG_BYTES = 11'd16;
	localparam logic [15:0] SEQ_HALF = 16'h8000;
	localparam logic [15:0] SEQ_HALF_M1 = 16'h7FFF;
	localparam logic [48:0] ROC_LIMIT = 49'h1_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_NONCE = 3'd0,
		ST_INVALID = 3'd1,
		ST_COMMITTED = 3'd2,
		ST_AUTH_FAIL = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_CHECK = 2'd0,
		KIND_BAD = 2'd1,
		KIND_COMMIT = 2'd2
	} kind_t;

	typedef struct packed {
		logic command;
		logic [7:0] first_byte;
		logic [10:0] packet_length;
		logic [15:0] sequence_req;
		logic [31:0] source_id;
		logic auth_ok;
	} srit_item_t;

	typedef struct packed {
		status_t status;
		logic [63:0] nonce_counter;
		logic [31:0] nonce_source;
		logic [48:0] estimated_roc;
		logic [10:0] cipher_length;
	} srit_result_t;

	// One classified beat as it travels from the front end to the back end.
	typedef struct packed {
		kind_t kind;
		logic [15:0] seq_num;
		logic [31:0] source_id;
		logic auth_ok;
		logic [10:0] cipher_length;
	} srit_job_t;

endpackage

// ===== sv/srtp_rollover_index_tracker_core.sv =====
// An accepted beat passes the front queue, the lookup stage and the result register.
// The lookup stage takes no new beat until the update stage has retired the last one,
// so that a check always sees the previous commit.
// The front queue holds two beats, so input is taken while results stall, until full.
// Reset (arst_n low, asynchronous) empties the stream table, the queue and any pending
// check; no clearing pass is needed, the table is usable in the first cycle after reset.
module srtp_rollover_index_tracker_core #(
	parameter int STREAM_SLOTS = srit_pkg::STREAM_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input srit_pkg::srit_item_t item,
	output logic result_valid,
	input logic result_stall,
	output srit_pkg::srit_result_t result
);

	// The front end checks the header of a check command and computes the cipher
	// length. Every beat, good or bad, is queued, since a bad check also drops the
	// pending result and so must be ordered with the commits around it.
	logic job_valid;
	logic job_take;
	srit_pkg::srit_job_t job;

	srit_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.job_valid(job_valid),
		.job_take(job_take),
		.job(job)
	);

	// The back end looks the stream up in an associative compare over all slots,
	// then in its second stage estimates the roll-over counter or applies a commit,
	// and loads the result register. The result register holds while stalled.
	srit_back #(
		.STREAM_SLOTS(STREAM_SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(job_valid),
		.job_take(job_take),
		.job(job),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ===== sv/srit_front.sv =====
// Front end: header classification and the job queue toward the back end.
module srit_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input srit_pkg::srit_item_t item,
	output logic job_valid,
	input logic job_take,
	output srit_pkg::srit_job_t job
);

	localparam int PTR_W = (srit_pkg::QUEUE_DEPTH > 1) ? $clog2(srit_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(srit_pkg::QUEUE_DEPTH + 1);

	srit_pkg::srit_job_t queue_q [srit_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	srit_pkg::srit_job_t classified;
	logic push;
	logic pop;

	// A check with a short packet or a wrong first byte is flagged bad here.
	always_comb begin
		classified.seq_num = item.sequence_req;
		classified.source_id = item.source_id;
		classified.auth_ok = item.auth_ok;
		classified.cipher_length = item.packet_length - srit_pkg::TAG_BYTES;
		if (item.command == srit_pkg::CMD_COMMIT) begin
			classified.kind = srit_pkg::KIND_COMMIT;
		end else if (item.packet_length > srit_pkg::MIN_LENGTH &&
		             item.first_byte == srit_pkg::HDR_FIRST_BYTE) begin
			classified.kind = srit_pkg::KIND_CHECK;
		end else begin
			classified.kind = srit_pkg::KIND_BAD;
		end
	end

	assign item_stall = (count_q == CNT_W'(srit_pkg::QUEUE_DEPTH));
	assign push = item_valid && !item_stall;
	assign job_valid = (count_q != '0);
	assign pop = job_take && job_valid;
	assign job = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(srit_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(srit_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/srit_back.sv =====
// Back end: stream table lookup, roll-over estimate, commit and result register.
module srit_back #(
	parameter int STREAM_SLOTS = srit_pkg::STREAM_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_take,
	input srit_pkg::srit_job_t job,
	output logic result_valid,
	input logic result_stall,
	output srit_pkg::srit_result_t result
);

	localparam int IDX_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

	// Stream table.
	logic [STREAM_SLOTS-1:0] ent_valid_q;
	logic [31:0] ent_source_q [STREAM_SLOTS];
	logic [15:0] ent_seq_q [STREAM_SLOTS];
	logic [48:0] ent_roc_q [STREAM_SLOTS];

	// Outcome of the last check, waiting for its commit.
	logic pending_valid_q;
	logic pending_hit_q;
	logic [IDX_W-1:0] pending_idx_q;
	logic [31:0] pending_source_q;
	logic [15:0] pending_seq_q;
	logic [48:0] pending_roc_q;

	// Lookup stage.
	logic s1_valid_q;
	srit_pkg::srit_job_t job_s1;
	logic hit_s1;
	logic [IDX_W-1:0] hit_idx_s1;
	logic free_s1;
	logic [IDX_W-1:0] free_idx_s1;

	logic result_valid_q;
	srit_pkg::srit_result_t result_q;

	logic [STREAM_SLOTS-1:0] match;
	logic hit_any;
	logic [IDX_W-1:0] hit_idx;
	logic free_any;
	logic [IDX_W-1:0] free_idx;
	logic exec;

	logic [15:0] last_seq;
	logic [48:0] base_roc;
	logic [48:0] est_roc;
	logic dec_roc;
	logic inc_roc;
	srit_pkg::srit_result_t res;
	logic wr_en;
	logic wr_new;
	logic [IDX_W-1:0] wr_idx;
	logic pend_set;
	logic pend_clr;

	// The stage below must retire before the next lookup so that it sees the update.
	assign job_take = job_valid && !s1_valid_q;
	assign exec = s1_valid_q && (!result_valid_q || !result_stall);

	always_comb begin
		for (int i = 0; i < STREAM_SLOTS; i++) begin
			match[i] = ent_valid_q[i] && (ent_source_q[i] == job.source_id);
		end
	end

	// Lowest matching slot and lowest free slot.
	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = STREAM_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (!ent_valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign hit_any = |match;
	assign free_any = ~&ent_valid_q;

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_s1 <= job;
			hit_s1 <= hit_any;
			hit_idx_s1 <= hit_idx;
			free_s1 <= free_any;
			free_idx_s1 <= free_idx;
		end
	end

	// An unknown stream starts from sequence zero and roll-over counter zero.
	always_comb begin
		last_seq = hit_s1 ? ent_seq_q[hit_idx_s1] : '0;
		base_roc = hit_s1 ? ent_roc_q[hit_idx_s1] : '0;
		dec_roc = (last_seq < srit_pkg::SEQ_HALF) &&
		          (({1'b0, last_seq} + {1'b0, srit_pkg::SEQ_HALF}) < {1'b0, job_s1.seq_num}) &&
		          (base_roc != '0);
		inc_roc = (last_seq > srit_pkg::SEQ_HALF_M1) &&
		          ((last_seq - srit_pkg::SEQ_HALF) > job_s1.seq_num) &&
		          (base_roc < srit_pkg::ROC_LIMIT);
		if (dec_roc) begin
			est_roc = base_roc - 49'd1;
		end else if (inc_roc) begin
			est_roc = base_roc + 49'd1;
		end else begin
			est_roc = base_roc;
		end
	end

	always_comb begin
		res = '0;
		res.status = srit_pkg::ST_INVALID;
		wr_en = 1'b0;
		wr_new = 1'b0;
		wr_idx = pending_idx_q;
		pend_set = 1'b0;
		pend_clr = 1'b0;
		case (job_s1.kind)
			srit_pkg::KIND_CHECK: begin
				pend_set = 1'b1;
				res.status = srit_pkg::ST_NONCE;
				res.nonce_counter = {est_roc[47:0], job_s1.seq_num};
				res.nonce_source = job_s1.source_id;
				res.estimated_roc = est_roc;
				res.cipher_length = job_s1.cipher_length;
			end
			srit_pkg::KIND_COMMIT: begin
				if (pending_valid_q) begin
					pend_clr = 1'b1;
					if (!job_s1.auth_ok) begin
						res.status = srit_pkg::ST_AUTH_FAIL;
					end else if (pending_hit_q) begin
						wr_en = 1'b1;
						res.status = srit_pkg::ST_COMMITTED;
					end else if (free_s1) begin
						wr_en = 1'b1;
						wr_new = 1'b1;
						wr_idx = free_idx_s1;
						res.status = srit_pkg::ST_COMMITTED;
					end else begin
						res.status = srit_pkg::ST_FULL;
					end
				end
			end
			default: begin
				pend_clr = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec && wr_en) begin
			ent_seq_q[wr_idx] <= pending_seq_q;
			ent_roc_q[wr_idx] <= pending_roc_q;
			if (wr_new) begin
				ent_source_q[wr_idx] <= pending_source_q;
			end
		end
		if (exec) begin
			result_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			s1_valid_q <= 1'b0;
			result_valid_q <= 1'b0;
			pending_valid_q <= 1'b0;
			pending_hit_q <= 1'b0;
			pending_idx_q <= '0;
			pending_source_q <= '0;
			pending_seq_q <= '0;
			pending_roc_q <= '0;
		end else begin
			if (job_take) begin
				s1_valid_q <= 1'b1;
			end else if (exec) begin
				s1_valid_q <= 1'b0;
			end
			if (exec) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (exec && wr_en && wr_new) begin
				ent_valid_q[wr_idx] <= 1'b1;
			end
			if (exec && pend_set) begin
				pending_valid_q <= 1'b1;
				pending_hit_q <= hit_s1;
				pending_idx_q <= hit_idx_s1;
				pending_source_q <= job_s1.source_id;
				pending_seq_q <= job_s1.seq_num;
				pending_roc_q <= est_roc;
			end else if (exec && pend_clr) begin
				pending_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== sv/srit_checker.sv =====
// Port-level checker for the roll-over index tracker and its bind.
module srit_checker (
	input logic clk,
	input logic arst_n,
	input srit_pkg::srit_result_t result,
	input logic result_valid,
	input logic result_stall
);

	// A stalled result beat stays and does not change.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// Anything but a nonce result carries all-zero data fields.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != srit_pkg::ST_NONCE |->
		result.nonce_counter == '0 && result.nonce_source == '0 &&
		result.estimated_roc == '0 && result.cipher_length == '0)
		else $error("non-nonce result with data fields set");

	// The nonce counter carries the estimated roll-over counter above the sequence.
	a_nonce_roc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == srit_pkg::ST_NONCE |->
		result.nonce_counter[63:16] == result.estimated_roc[47:0])
		else $error("nonce counter does not match estimated roc");

	// A nonce result comes only from a packet longer than 28 bytes.
	a_nonce_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == srit_pkg::ST_NONCE |->
		result.cipher_length >= 11'd13)
		else $error("nonce result with too short a cipher length");

	// A result beat carries one of the five defined status codes.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status <= srit_pkg::ST_FULL)
		else $error("result status out of range");

endmodule

bind srtp_rollover_index_tracker_core srit_checker u_srit_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result(result),
	.result_valid(result_valid),
	.result_stall(result_stall)
);

// ===== sim/srtp_rollover_index_tracker_core_test.sv =====
// Self-checking testbench of the SRTP roll-over index tracker core.
`timescale 1ns / 100ps

// The testbench drives header checks and commit verdicts into the core and
// predicts every result beat with its own copy of the stream table and the
// pending check. A directed opening covers the header limits, every status but
// FULL and both roll-over corrections. Then a long random phase, made mostly of
// check/commit pairs on a small pool of streams, so that the table fills up
// and sequence numbers wrap. Both handshakes see random idle and stall time.
module srtp_rollover_index_tracker_core_test;

	localparam int SLOTS = srit_pkg::STREAM_SLOTS_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int POOL_SIZE = 14;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 12;
	localparam logic [7:0] GOOD_FB = srit_pkg::HDR_FIRST_BYTE;

	// Receiver behaviors. Each one holds for a random stretch of cycles.
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_COMB
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	srit_pkg::srit_item_t item_beat = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	srit_pkg::srit_result_t result_beat;

	srtp_rollover_index_tracker_core #(
		.STREAM_SLOTS(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_beat),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_beat)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Predicted stream table. Entries are only read once they are marked used,
	// so their initial contents never matter.
	bit slot_used[SLOTS];
	logic [31:0] slot_ssrc[SLOTS];
	logic [15:0] slot_seq[SLOTS];
	logic [48:0] slot_roc[SLOTS];

	// The check that waits for its verdict. A slot of SLOTS means the stream
	// was not in the table when it was checked.
	bit held_valid = 1'b0;
	int held_slot = 0;
	logic [31:0] held_ssrc = '0;
	logic [15:0] held_seq = '0;
	logic [48:0] held_roc = '0;

	srit_pkg::srit_item_t packet_q[$];
	srit_pkg::srit_result_t outcome_q[$];
	int error_count = 0;
	int idle_cycles = 0;
	bit in_acc = 1'b0;

	int burst_left = 0;
	int gap_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int stall_phase_left = 0;
	int stall_tick = 0;

	logic [31:0] pool_ssrc[POOL_SIZE];
	logic [15:0] pool_last[POOL_SIZE];

	// Applies one accepted beat to the predicted context and returns the
	// result beat that the core must produce for it.
	function automatic srit_pkg::srit_result_t track_packet(input srit_pkg::srit_item_t it);
		srit_pkg::srit_result_t r;
		int hit;
		int k;
		logic [15:0] last;
		logic [48:0] roc;
		r = '0;
		r.status = srit_pkg::ST_INVALID;
		hit = SLOTS;
		last = '0;
		roc = '0;
		if (it.command == srit_pkg::CMD_CHECK) begin
			if (it.packet_length > srit_pkg::MIN_LENGTH && it.first_byte == GOOD_FB) begin
				// Scan downward so that the lowest matching slot wins.
				for (k = SLOTS - 1; k >= 0; k--) begin
					if (slot_used[k] && slot_ssrc[k] == it.source_id)
						hit = k;
				end
				if (hit < SLOTS) begin
					last = slot_seq[hit];
					roc = slot_roc[hit];
				end
				// A jump of more than half the sequence space backward across the
				// wrap belongs to the previous roll-over period, and a jump forward
				// across it to the next one. Both stop at their limits.
				if (last < srit_pkg::SEQ_HALF
						&& {1'b0, last} + {1'b0, srit_pkg::SEQ_HALF} < {1'b0, it.sequence_req}
						&& roc != '0)
					roc = roc - 49'd1;
				else if (last > srit_pkg::SEQ_HALF_M1
						&& last - srit_pkg::SEQ_HALF > it.sequence_req
						&& roc < srit_pkg::ROC_LIMIT)
					roc = roc + 49'd1;
				held_valid = 1'b1;
				held_slot = hit;
				held_ssrc = it.source_id;
				held_seq = it.sequence_req;
				held_roc = roc;
				r.status = srit_pkg::ST_NONCE;
				r.nonce_counter = {roc[47:0], it.sequence_req};
				r.nonce_source = it.source_id;
				r.estimated_roc = roc;
				r.cipher_length = it.packet_length - srit_pkg::TAG_BYTES;
			end else begin
				// A malformed header throws away whatever check was pending.
				held_valid = 1'b0;
			end
		end else if (held_valid) begin
			held_valid = 1'b0;
			if (!it.auth_ok) begin
				r.status = srit_pkg::ST_AUTH_FAIL;
			end else begin
				hit = held_slot;
				if (hit >= SLOTS) begin
					for (k = SLOTS - 1; k >= 0; k--) begin
						if (!slot_used[k])
							hit = k;
					end
				end
				if (hit >= SLOTS) begin
					r.status = srit_pkg::ST_FULL;
				end else begin
					slot_used[hit] = 1'b1;
					slot_ssrc[hit] = held_ssrc;
					slot_seq[hit] = held_seq;
					slot_roc[hit] = held_roc;
					r.status = srit_pkg::ST_COMMITTED;
				end
			end
		end
		return r;
	endfunction

	// A check beat. The verdict bit is meaningless here, so it is random.
	function automatic srit_pkg::srit_item_t check_beat(input logic [7:0] fb,
			input logic [10:0] len, input logic [15:0] seq, input logic [31:0] ssrc);
		srit_pkg::srit_item_t it;
		it.command = srit_pkg::CMD_CHECK;
		it.first_byte = fb;
		it.packet_length = len;
		it.sequence_req = seq;
		it.source_id = ssrc;
		it.auth_ok = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// A commit beat. Only the verdict matters; the header fields carry noise.
	function automatic srit_pkg::srit_item_t commit_beat(input logic ok);
		srit_pkg::srit_item_t it;
		it.command = srit_pkg::CMD_COMMIT;
		it.first_byte = 8'($urandom);
		it.packet_length = 11'($urandom_range(0, 1500));
		it.sequence_req = 16'($urandom);
		it.source_id = $urandom;
		it.auth_ok = ok;
		return it;
	endfunction

	// Random traffic. Most of it is a well-formed check followed by a verdict,
	// with sequence numbers that step, reorder and jump across the wrap so that
	// the roll-over counter moves both ways. The rest is malformed headers,
	// stray commits and checks that replace one another.
	task automatic queue_random_traffic();
		int n;
		int pick;
		int k;
		logic [15:0] s;
		logic [31:0] ssrc;
		n = 0;
		while (n < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, POOL_SIZE - 1);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: s = pool_last[k] + 16'($urandom_range(1, 64));
				4, 5: s = pool_last[k] + 16'($urandom_range(16'h6000, 16'h7FFF));
				6: s = pool_last[k] - 16'($urandom_range(16'h6000, 16'h7FFF));
				7: s = pool_last[k] - 16'($urandom_range(1, 300));
				8: s = 16'($urandom);
				default: s = pool_last[k];
			endcase
			// Now and then a stream that was never seen, which eventually finds
			// the table full.
			ssrc = ($urandom_range(0, 11) == 0) ? $urandom : pool_ssrc[k];
			if (pick < 75) begin
				packet_q.push_back(check_beat(GOOD_FB, 11'($urandom_range(29, 1500)), s,
					ssrc));
				pool_last[k] = s;
				packet_q.push_back(commit_beat($urandom_range(0, 11) != 0));
				n += 2;
			end else if (pick < 85) begin
				if ($urandom_range(0, 1) == 0)
					packet_q.push_back(check_beat(GOOD_FB, 11'($urandom_range(0, 28)), s,
						ssrc));
				else
					packet_q.push_back(check_beat(8'($urandom), 11'($urandom_range(0, 1500)), s,
						ssrc));
				packet_q.push_back(commit_beat(1'b1));
				n += 2;
			end else if (pick < 92) begin
				packet_q.push_back(commit_beat(1'($urandom_range(0, 1))));
				n += 1;
			end else begin
				packet_q.push_back(check_beat(GOOD_FB, 11'($urandom_range(29, 1500)),
					16'($urandom), ssrc));
				packet_q.push_back(check_beat(GOOD_FB, 11'($urandom_range(29, 1500)), s,
					ssrc));
				pool_last[k] = s;
				packet_q.push_back(commit_beat(1'b1));
				n += 3;
			end
		end
	endtask

	// Sender. A new beat is offered only once the previous one was taken, and
	// bursts of back-to-back beats alternate with idle gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || in_acc) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (packet_q.size() == 0) begin
				item_valid <= 1'b0;
			end else begin
				item_beat <= packet_q.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver. It switches between no stall, light and heavy random stall,
	// and a regular on/off pattern.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (stall_phase_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_phase_left <= $urandom_range(16, 96);
			end else begin
				stall_phase_left <= stall_phase_left - 1;
			end
			case (stall_mode)
				STALL_NONE: result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				default: result_stall <= stall_tick[2];
			endcase
		end
	end

	// Checker and watchdog. The outgoing beat is compared before the incoming
	// one is predicted, since a result always belongs to an older input beat.
	always @(posedge clk) begin
		srit_pkg::srit_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (outcome_q.size() == 0) begin
					$error("result beat with nothing expected: status %0d", result_beat.status);
					error_count++;
				end else begin
					want = outcome_q.pop_front();
					if (result_beat.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result_beat.status);
						error_count++;
					end
					if (result_beat.nonce_counter !== want.nonce_counter) begin
						$error("nonce_counter: expected %h, got %h", want.nonce_counter,
							result_beat.nonce_counter);
						error_count++;
					end
					if (result_beat.nonce_source !== want.nonce_source) begin
						$error("nonce_source: expected %h, got %h", want.nonce_source,
							result_beat.nonce_source);
						error_count++;
					end
					if (result_beat.estimated_roc !== want.estimated_roc) begin
						$error("estimated_roc: expected %h, got %h", want.estimated_roc,
							result_beat.estimated_roc);
						error_count++;
					end
					if (result_beat.cipher_length !== want.cipher_length) begin
						$error("cipher_length: expected %0d, got %0d", want.cipher_length,
							result_beat.cipher_length);
						error_count++;
					end
				end
			end
			in_acc = item_valid && !item_stall;
			if (in_acc)
				outcome_q.push_back(track_packet(item_beat));
			if (in_acc || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		for (int k = 0; k < POOL_SIZE; k++) begin
			pool_ssrc[k] = $urandom;
			pool_last[k] = 16'($urandom);
		end

		// Directed opening. Stream all-ones walks through a wrap and back.
		packet_q.push_back(commit_beat(1'b1));                               // nothing pending
		packet_q.push_back(check_beat(GOOD_FB, 11'd28, 16'h1234, 32'h1));    // too short
		packet_q.push_back(check_beat(8'h81, 11'd29, 16'h1234, 32'h1));      // wrong first byte
		packet_q.push_back(check_beat(8'h00, 11'd0, 16'h0000, 32'h0));
		packet_q.push_back(check_beat(8'hFF, 11'd1500, 16'hFFFF, 32'hFFFF_FFFF));
		packet_q.push_back(check_beat(GOOD_FB, 11'd29, 16'hFFFF, 32'hFFFF_FFFF));
		packet_q.push_back(commit_beat(1'b0));                               // verdict bad
		packet_q.push_back(commit_beat(1'b1));                               // already consumed
		packet_q.push_back(check_beat(GOOD_FB, 11'd1500, 16'hF000, 32'hFFFF_FFFF));
		packet_q.push_back(commit_beat(1'b1));                               // new stream
		packet_q.push_back(check_beat(GOOD_FB, 11'd200, 16'h0010, 32'hFFFF_FFFF));
		packet_q.push_back(check_beat(GOOD_FB, 11'd201, 16'h0011, 32'hFFFF_FFFF));
		packet_q.push_back(commit_beat(1'b1));                               // counter now one
		packet_q.push_back(check_beat(GOOD_FB, 11'd64, 16'h9000, 32'hFFFF_FFFF));
		packet_q.push_back(commit_beat(1'b0));
		packet_q.push_back(check_beat(GOOD_FB, 11'd100, 16'h0000, 32'h0));
		packet_q.push_back(commit_beat(1'b1));
		packet_q.push_back(check_beat(GOOD_FB, 11'd1024, 16'h9000, 32'hFFFF_FFFF));
		packet_q.push_back(check_beat(GOOD_FB, 11'd28, 16'h9000, 32'hFFFF_FFFF));
		packet_q.push_back(commit_beat(1'b1));                               // check was dropped
		packet_q.push_back(check_beat(GOOD_FB, 11'd777, 16'h8000, 32'h0));
		packet_q.push_back(commit_beat(1'b1));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Hold the sender back until every directed result is in.
		while (packet_q.size() != 0 || item_valid || outcome_q.size() != 0)
			@(posedge clk);

		queue_random_traffic();

		while (packet_q.size() != 0 || item_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
